[rtl/jctg_pkg.sv]
// ----------------------------------------------------------------------------
// jctg_pkg
// Types and constants shared by the JBIG context template generator.
// ----------------------------------------------------------------------------
package jctg_pkg;

	// Function codes of a pixel request
	localparam logic [1:0] FUNC_RESET = 2'd0;
	localparam logic [1:0] FUNC_SLNTP = 2'd1;
	localparam logic [1:0] FUNC_PIXEL = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_TWO_LINE  = 2'd0;
	localparam logic [1:0] REG_AT_ENABLE = 2'd1;
	localparam logic [1:0] REG_AT_OFFSET = 2'd2;
	localparam logic [1:0] REG_AT_START  = 2'd3;

	// Fixed contexts of the SLNTP pseudo-pixel
	localparam logic [9:0] CX_SLNTP_TWO   = 10'h195;
	localparam logic [9:0] CX_SLNTP_THREE = 10'h0e5;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	typedef struct packed {
		logic [1:0]  func;
		logic        slntp_bit;
		logic        line_not_typical;
		logic [15:0] stripe_line;
		logic        above2_ahead1;
		logic        above1_ahead1;
		logic        above1_ahead2;
		logic        at_pixel;
		logic        left_pixel;
	} pixel_t;

	typedef struct packed {
		logic [9:0] context_res;
		logic       use_coder;
		logic       coded_bit;
	} ctx_t;

	// Register file contents handed to the context logic
	typedef struct packed {
		logic        two_line_template;
		logic        at_enable;
		logic [6:0]  at_offset;
		logic [15:0] at_start_line;
	} cfg_t;

endpackage

[rtl/jctg_cfg.sv]
// ----------------------------------------------------------------------------
// jctg_cfg
// Configuration register file; a write request is taken every cycle.
// ----------------------------------------------------------------------------
module jctg_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [jctg_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [jctg_pkg::CFG_DATA_W-1:0]    cfg_data,
	output jctg_pkg::cfg_t                     cfg
);

	jctg_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				jctg_pkg::REG_TWO_LINE:  cfg_q.two_line_template <= cfg_data[0];
				jctg_pkg::REG_AT_ENABLE: cfg_q.at_enable         <= cfg_data[0];
				jctg_pkg::REG_AT_OFFSET: cfg_q.at_offset         <= cfg_data[6:0];
				jctg_pkg::REG_AT_START:  cfg_q.at_start_line     <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

[rtl/jctg_ctx.sv]
// ----------------------------------------------------------------------------
// jctg_ctx
// Pixel windows and context formation for the registered pixel request.
// Windows update on the cycle the request leaves the input register.
// ----------------------------------------------------------------------------
module jctg_ctx (
	input  logic               clk,
	input  logic               arst_n,
	input  jctg_pkg::cfg_t     cfg,
	input  jctg_pkg::pixel_t   pix,
	input  logic               advance,
	output logic               has_result,
	output jctg_pkg::ctx_t     result
);

	logic [2:0] two_above_q;
	logic [5:0] one_above_q;
	logic [3:0] current_q;

	logic [2:0] two_above_nx;
	logic [5:0] one_above_nx;
	logic [3:0] current_nx;
	logic       at_on;
	logic       coded_pixel;

	assign at_on = cfg.at_enable && (cfg.at_offset != 7'd0)
		&& (pix.stripe_line >= cfg.at_start_line);
	assign coded_pixel = (pix.func == jctg_pkg::FUNC_PIXEL) && pix.line_not_typical;
	assign has_result  = (pix.func == jctg_pkg::FUNC_SLNTP)
		|| (pix.func == jctg_pkg::FUNC_PIXEL);

	// shifted windows for a coded pixel
	always_comb begin
		current_nx   = {current_q[2:0], pix.left_pixel};
		two_above_nx = two_above_q;
		if (cfg.two_line_template) begin
			if (at_on) begin
				one_above_nx = {one_above_q[4:1], pix.above1_ahead1, pix.at_pixel};
			end else begin
				one_above_nx = {one_above_q[4:0], pix.above1_ahead2};
			end
		end else begin
			two_above_nx = {two_above_q[1:0], pix.above2_ahead1};
			if (at_on) begin
				one_above_nx = {1'b0, one_above_q[3:1], pix.above1_ahead1, pix.at_pixel};
			end else begin
				one_above_nx = {1'b0, one_above_q[3:0], pix.above1_ahead2};
			end
		end
	end

	// result fields
	always_comb begin
		result = '0;
		if (pix.func == jctg_pkg::FUNC_SLNTP) begin
			result.context_res = cfg.two_line_template ? jctg_pkg::CX_SLNTP_TWO
				: jctg_pkg::CX_SLNTP_THREE;
			result.use_coder   = 1'b1;
			result.coded_bit   = pix.slntp_bit;
		end else if (coded_pixel) begin
			result.use_coder = 1'b1;
			if (cfg.two_line_template) begin
				result.context_res = {one_above_nx, current_nx};
			end else begin
				result.context_res = {two_above_nx, one_above_nx[4:0], current_nx[1:0]};
			end
		end
	end

	// window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			two_above_q <= '0;
			one_above_q <= '0;
			current_q   <= '0;
		end else if (advance) begin
			if (pix.func == jctg_pkg::FUNC_RESET) begin
				two_above_q <= '0;
				one_above_q <= '0;
				current_q   <= '0;
			end else if (coded_pixel) begin
				two_above_q <= two_above_nx;
				one_above_q <= one_above_nx;
				current_q   <= current_nx;
			end
		end
	end

endmodule

[rtl/jbig_context_template_generator.sv]
// ----------------------------------------------------------------------------
// jbig_context_template_generator
// JBIG context template generator: one 10-bit coder context per pixel.
// ----------------------------------------------------------------------------
//  channel  | signals                                  | carries
//  pixel    | pixel_valid, pixel_ready, pixel          | one pixel request
//  ctx      | ctx_valid, ctx_ready, ctx                | context, coder flags
//  cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data| register write
//
// One pixel per cycle sustained while ctx_ready is high. A taken pixel sits in
// the input register until the result register is free or draining; its result
// is then registered in the result register and offered on ctx.
// Line start and unused function codes produce no result.
// A stalled result holds; the input register keeps accepting while the
// result register can drain. Reset clears windows, configuration and valid flags.
// ----------------------------------------------------------------------------
module jbig_context_template_generator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               pixel_valid,
	output logic                               pixel_ready,
	input  jctg_pkg::pixel_t                   pixel,
	output logic                               ctx_valid,
	input  logic                               ctx_ready,
	output jctg_pkg::ctx_t                     ctx,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [jctg_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [jctg_pkg::CFG_DATA_W-1:0]    cfg_data
);

	jctg_pkg::cfg_t   cfg;
	jctg_pkg::pixel_t pix_s1;
	logic             valid_s1;
	jctg_pkg::ctx_t   result;
	jctg_pkg::ctx_t   ctx_s2;
	logic             valid_s2;
	logic             has_result;
	logic             advance;

	jctg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	jctg_ctx u_ctx (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.pix        (pix_s1),
		.advance    (advance),
		.has_result (has_result),
		.result     (result)
	);

	// stage 1 moves on when the result register is free or draining
	assign advance     = valid_s1 && (!valid_s2 || ctx_ready);
	assign pixel_ready = !valid_s1 || advance;
	assign ctx_valid   = valid_s2;
	assign ctx         = ctx_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel_ready) begin
			valid_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pixel_valid && pixel_ready) begin
			pix_s1 <= pixel;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= has_result;
		end else if (ctx_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			ctx_s2 <= result;
		end
	end

endmodule

[rtl/jctg_checker.sv]
// ----------------------------------------------------------------------------
// jctg_checker
// Port-level checks of the context template generator, bound to the top.
// ----------------------------------------------------------------------------
module jctg_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               pixel_ready,
	input logic                               ctx_valid,
	input logic                               ctx_ready,
	input jctg_pkg::ctx_t                     ctx,
	input logic                               cfg_valid,
	input logic                               cfg_ready
);

	// a stalled result holds
	a_ctx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ctx_valid && !ctx_ready |=> ctx_valid && $stable(ctx))
		else $error("result changed while stalled");

	// with the result register empty a pixel request is always taken
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!ctx_valid |-> pixel_ready)
		else $error("pixel request refused with empty result register");

	// typical-line results carry no context and no bit
	a_typical_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ctx_valid && !ctx.use_coder |-> ctx.context_res == 10'd0 && !ctx.coded_bit)
		else $error("typical-line result not cleared");

	// a coded bit only comes with an SLNTP context
	a_slntp_context: assert property (@(posedge clk) disable iff (!arst_n)
		ctx_valid && ctx.coded_bit |-> ctx.use_coder
			&& (ctx.context_res == jctg_pkg::CX_SLNTP_TWO
			|| ctx.context_res == jctg_pkg::CX_SLNTP_THREE))
		else $error("coded bit outside SLNTP context");

	// configuration writes never stall
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind jbig_context_template_generator jctg_checker u_jctg_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pixel_ready (pixel_ready),
	.ctx_valid   (ctx_valid),
	.ctx_ready   (ctx_ready),
	.ctx         (ctx),
	.cfg_valid   (cfg_valid),
	.cfg_ready   (cfg_ready)
);
